// ===== rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the wheel speed steering DAC unit.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int TS_BITS   = 16;
    localparam int SPD_BITS  = 16;
    localparam int DVS_W     = 16;
    localparam int PCT_BITS  = 7;
    localparam int DAC_BITS  = 12;
    localparam int DIV_W     = 23;

    localparam int SPEED_NUM64 = 100000000 / 64;

    localparam logic [SPD_BITS-1:0] SPD_MAX = '1;

    localparam int DAC_CENTRE = 1 << (DAC_BITS - 1);
    localparam int DAC_MAX    = (1 << DAC_BITS) - 1;
    localparam int P_HI_R     = (DAC_CENTRE - 1) * 100;
    localparam int P_HI_L     = DAC_CENTRE * 100;
    localparam int X_W        = $clog2(2 * DAC_CENTRE * 100 + 1);

    // x / 100 == (x * RCP_K) >> RCP_SH for x below 2**X_W
    localparam int RCP_K  = 671089;
    localparam int RCP_SH = 26;
    localparam int RCP_W  = 20;

    localparam logic [1:0] REG_BAND = 2'd0;
    localparam logic [1:0] REG_MIN  = 2'd1;
    localparam logic [1:0] REG_GAIN = 2'd2;

    typedef struct packed {
        logic [TS_BITS-1:0] right_prev_time;
        logic [TS_BITS-1:0] right_last_time;
        logic [TS_BITS-1:0] left_prev_time;
        logic [TS_BITS-1:0] left_last_time;
    } t_in;

    typedef struct packed {
        logic [SPD_BITS-1:0] right_speed;
        logic [SPD_BITS-1:0] left_speed;
        logic [DAC_BITS-1:0] dac_code;
        logic                right_is_faster;
    } t_out;

    typedef struct packed {
        logic [PCT_BITS-1:0] band;
        logic [15:0]         min_slow;
        logic [15:0]         gain;
    } t_cfg;

endpackage

// ===== rtl/wsd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module wsd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [wsd_pkg::DIV_W-1:0]  i_dvd,
    input  logic [wsd_pkg::DVS_W-1:0]  i_dvs,
    output logic                       o_vld,
    output logic [wsd_pkg::DIV_W-1:0]  o_quo
);
    import wsd_pkg::*;

    logic [DVS_W-1:0] r_rem [DIV_W];
    logic [DIV_W-1:0] r_acc [DIV_W];
    logic [DVS_W-1:0] r_dvs [DIV_W];
    logic             r_vld [DIV_W];

    for (genvar s = 0; s < DIV_W; s++) begin : g_stage
        logic [DVS_W-1:0] rem_in;
        logic [DIV_W-1:0] acc_in;
        logic [DVS_W-1:0] dvs_in;
        logic             vld_in;
        logic [DVS_W:0]   t;
        logic             ge;
        logic [DVS_W:0]   diff;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign acc_in = i_dvd;
            assign dvs_in = i_dvs;
            assign vld_in = i_vld;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign acc_in = r_acc[s-1];
            assign dvs_in = r_dvs[s-1];
            assign vld_in = r_vld[s-1];
        end

        assign t    = {rem_in, acc_in[DIV_W-1]};
        assign ge   = t >= {1'b0, dvs_in};
        assign diff = t - {1'b0, dvs_in};

        always_ff @(posedge i_clk) begin
            r_rem[s] <= ge ? diff[DVS_W-1:0] : t[DVS_W-1:0];
            r_acc[s] <= {acc_in[DIV_W-2:0], ge};
            r_dvs[s] <= dvs_in;
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end
    end

    assign o_vld = r_vld[DIV_W-1];
    assign o_quo = r_acc[DIV_W-1];

endmodule

// ===== rtl/wsd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_lane
// One wheel: edge interval, speed division and saturation.
// ----------------------------------------------------------------------------
module wsd_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [wsd_pkg::TS_BITS-1:0]   i_prev,
    input  logic [wsd_pkg::TS_BITS-1:0]   i_last,
    output logic                          o_vld,
    output logic [wsd_pkg::SPD_BITS-1:0]  o_speed
);
    import wsd_pkg::*;

    logic [TS_BITS-1:0]  ivl;
    logic                d_vld;
    logic [DIV_W-1:0]    d_quo;
    logic                r_vld;
    logic [SPD_BITS-1:0] r_speed;

    // wrap: all ones minus prev plus last
    assign ivl = i_last - i_prev - TS_BITS'(i_last < i_prev);

    wsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_dvd   (DIV_W'(SPEED_NUM64)),
        .i_dvs   (DVS_W'(ivl)),
        .o_vld   (d_vld),
        .o_quo   (d_quo)
    );

    always_ff @(posedge i_clk) begin
        r_speed <= (|d_quo[DIV_W-1:SPD_BITS]) ? SPD_MAX : d_quo[SPD_BITS-1:0];
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= d_vld;
        end
    end

    assign o_vld   = r_vld;
    assign o_speed = r_speed;

endmodule

// ===== rtl/wsd_steer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_steer
// Merge stage: percent excess, dead band and gain to the DAC code.
// ----------------------------------------------------------------------------
module wsd_steer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [wsd_pkg::SPD_BITS-1:0]  i_sr,
    input  logic [wsd_pkg::SPD_BITS-1:0]  i_sl,
    input  wsd_pkg::t_cfg                 i_cfg,
    output logic                          o_vld,
    output wsd_pkg::t_out                 o_out
);
    import wsd_pkg::*;

    logic                right;
    logic [SPD_BITS-1:0] fast;
    logic [SPD_BITS-1:0] slow;
    logic                d_vld;
    logic [DIV_W-1:0]    d_quo;

    logic [SPD_BITS-1:0] r_sr [DIV_W];
    logic [SPD_BITS-1:0] r_sl [DIV_W];

    logic [DIV_W-1:0]    xs;
    logic [15:0]         ex;
    logic [SPD_BITS-1:0] dsr;
    logic [SPD_BITS-1:0] dsl;
    logic                b_rt;
    logic [SPD_BITS-1:0] b_slow;

    logic                r_b_vld, r_b_rt, r_b_ctr;
    logic [15:0]         r_b_diff;
    logic [SPD_BITS-1:0] r_b_sr, r_b_sl;
    logic                r_c_vld, r_c_rt, r_c_ctr;
    logic [31:0]         r_c_p;
    logic [SPD_BITS-1:0] r_c_sr, r_c_sl;

    logic [X_W-1:0]          x;
    logic [X_W+RCP_W-1:0]    prod;
    logic [DAC_BITS-1:0]     q;
    logic [DAC_BITS-1:0]     n_code;
    logic                    r_vld;
    t_out                    r_out;

    assign right = i_sr > i_sl;
    assign fast  = right ? i_sr : i_sl;
    assign slow  = right ? i_sl : i_sr;

    wsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_dvd   (DIV_W'(fast) * DIV_W'(100)),
        .i_dvs   (DVS_W'(slow)),
        .o_vld   (d_vld),
        .o_quo   (d_quo)
    );

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DIV_W; i++) begin
            r_sr[i] <= (i == 0) ? i_sr : r_sr[(i == 0) ? 0 : i-1];
            r_sl[i] <= (i == 0) ? i_sl : r_sl[(i == 0) ? 0 : i-1];
        end
    end

    assign dsr    = r_sr[DIV_W-1];
    assign dsl    = r_sl[DIV_W-1];
    assign b_rt   = dsr > dsl;
    assign b_slow = b_rt ? dsl : dsr;
    assign xs     = d_quo - DIV_W'(100);
    assign ex     = (|xs[DIV_W-1:16]) ? 16'hFFFF : xs[15:0];

    assign x    = r_c_rt ? X_W'(P_HI_L) + X_W'(r_c_p) : X_W'(P_HI_L) - X_W'(r_c_p);
    assign prod = (X_W+RCP_W)'(x) * (X_W+RCP_W)'(RCP_K);
    assign q    = prod[RCP_SH +: DAC_BITS];

    always_comb begin
        n_code = q;
        if (r_c_ctr) begin
            n_code = DAC_BITS'(DAC_CENTRE);
        end else if (r_c_rt) begin
            if (r_c_p > 32'(P_HI_R)) begin
                n_code = DAC_BITS'(DAC_MAX);
            end
        end else if (r_c_p > 32'(P_HI_L)) begin
            n_code = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_rt   <= b_rt;
        r_b_ctr  <= (dsr == dsl) || (ex < 16'(i_cfg.band)) || (b_slow < i_cfg.min_slow);
        r_b_diff <= ex - 16'(i_cfg.band);
        r_b_sr   <= dsr;
        r_b_sl   <= dsl;

        r_c_rt   <= r_b_rt;
        r_c_ctr  <= r_b_ctr;
        r_c_p    <= 32'(i_cfg.gain) * 32'(r_b_diff);
        r_c_sr   <= r_b_sr;
        r_c_sl   <= r_b_sl;

        r_out.right_speed     <= r_c_sr;
        r_out.left_speed      <= r_c_sl;
        r_out.dac_code        <= n_code;
        r_out.right_is_faster <= r_c_rt;

        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_b_vld <= d_vld;
            r_c_vld <= r_b_vld;
            r_vld   <= r_c_vld;
        end
    end

    assign o_vld = r_vld;
    assign o_out = r_out;

    a_eq_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && (r_out.right_speed == r_out.left_speed)
        |-> r_out.dac_code == DAC_BITS'(DAC_CENTRE))
        else $error("equal speeds must give centre code");

    a_dir_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> r_out.right_is_faster == (r_out.right_speed > r_out.left_speed))
        else $error("direction flag disagrees with speeds");

    a_left_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_out.right_is_faster |-> r_out.dac_code <= DAC_BITS'(DAC_CENTRE))
        else $error("left faster drove code above centre");

    a_right_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_out.right_is_faster |-> r_out.dac_code >= DAC_BITS'(DAC_CENTRE))
        else $error("right faster drove code below centre");

endmodule

// ===== rtl/wheel_speed_steering_dac_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_speed_steering_dac_unit
// Two wheel timestamp pairs to wheel speeds and a steering DAC code.
// ----------------------------------------------------------------------------
// The unit takes one timestamp set every clock (o_busy is always low) and
// returns its result on o_out with a one cycle o_done strobe; results come
// out in order and cannot be held off. Each set passes through the two 23
// stage pipelined dividers in series: wheel speed, then percent excess, plus
// the speed saturation, dead band, gain multiply and scaling stages.
module wheel_speed_steering_dac_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  wsd_pkg::t_in   i_in,
    output logic           o_done,
    output wsd_pkg::t_out  o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import wsd_pkg::*;

    t_cfg                r_cfg;
    logic                acc;
    logic                wr;
    logic [1:0]          idx;
    logic                r_vld, l_vld;
    logic [SPD_BITS-1:0] r_spd, l_spd;

    assign o_busy = 1'b0;
    assign pready = 1'b1;
    assign acc    = i_start && !o_busy;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band     <= PCT_BITS'(30);
            r_cfg.min_slow <= 16'd555;
            r_cfg.gain     <= 16'd2925;
        end else if (wr) begin
            case (idx)
                REG_BAND: r_cfg.band     <= pwdata[PCT_BITS-1:0];
                REG_MIN:  r_cfg.min_slow <= pwdata[15:0];
                REG_GAIN: r_cfg.gain     <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BAND: prdata = 32'(r_cfg.band);
            REG_MIN:  prdata = 32'(r_cfg.min_slow);
            REG_GAIN: prdata = 32'(r_cfg.gain);
            default:  prdata = '0;
        endcase
    end

    wsd_lane u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (acc),
        .i_prev  (i_in.right_prev_time),
        .i_last  (i_in.right_last_time),
        .o_vld   (r_vld),
        .o_speed (r_spd)
    );

    wsd_lane u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (acc),
        .i_prev  (i_in.left_prev_time),
        .i_last  (i_in.left_last_time),
        .o_vld   (l_vld),
        .o_speed (l_spd)
    );

    wsd_steer u_steer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld && l_vld),
        .i_sr    (r_spd),
        .i_sl    (l_spd),
        .i_cfg   (r_cfg),
        .o_vld   (o_done),
        .o_out   (o_out)
    );

endmodule
